FILE: sv/segment_mmu_translate_macros.svh
// Assertion macros used by the checker file of the segment translation block.
`ifndef SEGMENT_MMU_TRANSLATE_MACROS_SVH
`define SEGMENT_MMU_TRANSLATE_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define SMMU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define SMMU_ASSERT_NEVER(label, cond, msg) \
  `SMMU_ASSERT(label, !(cond), msg)

`endif

FILE: sv/smmu_pkg.sv
// Types, constants and the entry lookup table of the segment translation block.
`default_nettype none

package smmu_pkg;

  localparam int NUM_SEGMENTS = 64;
  localparam int IDX_W        = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
  localparam int SEG_CODE_W   = 6;
  localparam int SEG_CODES    = 1 << SEG_CODE_W;
  localparam int ADDR_W       = 24;
  localparam int OFFSET_W     = 16;
  localparam int BYTE_W       = 8;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_XLATE = 1'b1;

  localparam logic [7:0] PORT_MODE       = 8'h00;
  localparam logic [7:0] PORT_POINTER    = 8'h01;
  localparam logic [7:0] PORT_BASE       = 8'h08;
  localparam logic [7:0] PORT_LIMIT      = 8'h09;
  localparam logic [7:0] PORT_ATTR       = 8'h0A;
  localparam logic [7:0] PORT_FIELD      = 8'h0B;
  localparam logic [7:0] PORT_BASE_INC   = 8'h0C;
  localparam logic [7:0] PORT_LIMIT_INC  = 8'h0D;
  localparam logic [7:0] PORT_ATTR_INC   = 8'h0E;
  localparam logic [7:0] PORT_FIELD_INC  = 8'h0F;
  localparam logic [7:0] PORT_COUNTER    = 8'h20;

  typedef enum logic [1:0] {
    FIELD_BASE_HI = 2'd0,
    FIELD_BASE_LO = 2'd1,
    FIELD_LIMIT   = 2'd2,
    FIELD_ATTR    = 2'd3
  } field_e;

  typedef logic [IDX_W-1:0] entry_lut_t [SEG_CODES];

  // Maps a six-bit segment code onto a table entry, modulo the table depth.
  function automatic entry_lut_t build_entry_lut();
    entry_lut_t lut;
    for (int i = 0; i < SEG_CODES; i++) begin
      lut[i] = IDX_W'(i % NUM_SEGMENTS);
    end
    return lut;
  endfunction

  localparam entry_lut_t ENTRY_LUT = build_entry_lut();

endpackage

`default_nettype wire

FILE: sv/smmu_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module smmu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  wire logic [WIDTH-1:0]                 wdata_i,
  input  wire logic                             re_i,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic      [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/segment_mmu_translate.sv
// Segment address translation: register-write transactions load descriptor bases,
// translate transactions return base * 256 + offset on phys_addr_o.
// A taken translate transaction reads the table RAM into stage 1, then the address add
// is registered on phys_addr_o; one transaction per cycle unless the output stalls.
// A table write is seen by a translation taken in the next cycle.
// Reset clears pointer, counter and the per-entry valid bits, so every base reads zero.
`default_nettype none

module segment_mmu_translate (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          func_i,
  input  wire logic [7:0]                    port_i,
  input  wire logic [smmu_pkg::BYTE_W-1:0]   wdata_i,
  input  wire logic [6:0]                    segment_i,
  input  wire logic [smmu_pkg::OFFSET_W-1:0] offset_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [smmu_pkg::ADDR_W-1:0]        phys_addr_o
);

  import smmu_pkg::*;

  logic                      in_accept;
  logic                      is_xlate;
  logic                      is_reg_wr;
  logic [IDX_W-1:0]          rd_idx;
  logic [IDX_W-1:0]          wr_idx;

  logic [SEG_CODE_W-1:0]     ptr_q, ptr_d;
  logic [1:0]                cnt_q, cnt_d;
  logic [1:0]                cnt_inc;
  logic                      put;
  field_e                    fsel;
  logic                      hi_we, lo_we;

  logic [NUM_SEGMENTS-1:0]   hi_vld_q, lo_vld_q;
  logic [BYTE_W-1:0]         hi_rdata, lo_rdata;

  logic                      s1_valid_q, s1_valid_d;
  logic                      s1_hi_vld_q, s1_lo_vld_q;
  logic [OFFSET_W-1:0]       s1_offset_q;
  logic                      s1_move;
  logic                      out_free;
  logic [2*BYTE_W-1:0]       base;
  logic [ADDR_W-1:0]         sum;

  logic                      out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]         phys_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign is_xlate   = in_accept && (func_i == FUNC_XLATE);
  assign is_reg_wr  = in_accept && (func_i == FUNC_WRITE);

  assign rd_idx  = ENTRY_LUT[segment_i[SEG_CODE_W-1:0]];
  assign wr_idx  = ENTRY_LUT[ptr_q];
  assign cnt_inc = cnt_q + 2'd1;

  // Limit, attribute and mode writes are decoded, but nothing reads those
  // fields, so only the two base bytes are stored.
  always_comb begin
    ptr_d = ptr_q;
    cnt_d = cnt_q;
    put   = 1'b0;
    fsel  = FIELD_LIMIT;
    if (is_reg_wr) begin
      unique case (port_i)
        PORT_POINTER: begin
          ptr_d = wdata_i[SEG_CODE_W-1:0];
          cnt_d = '0;
        end
        PORT_BASE: begin
          put   = 1'b1;
          fsel  = field_e'({1'b0, cnt_q[0]});
          cnt_d = cnt_inc;
        end
        PORT_FIELD: begin
          put   = 1'b1;
          fsel  = field_e'(cnt_q);
          cnt_d = cnt_inc;
        end
        PORT_BASE_INC: begin
          put   = 1'b1;
          fsel  = field_e'({1'b0, cnt_q[0]});
          ptr_d = ptr_q + 1'b1;
        end
        PORT_LIMIT_INC, PORT_ATTR_INC: begin
          ptr_d = ptr_q + 1'b1;
        end
        PORT_FIELD_INC: begin
          put   = 1'b1;
          fsel  = field_e'(cnt_q);
          cnt_d = cnt_inc;
          if (cnt_inc == '0) begin
            ptr_d = ptr_q + 1'b1;
          end
        end
        PORT_COUNTER: begin
          cnt_d = wdata_i[1:0];
        end
        PORT_MODE, PORT_LIMIT, PORT_ATTR: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign hi_we = put && (fsel == FIELD_BASE_HI);
  assign lo_we = put && (fsel == FIELD_BASE_LO);

  smmu_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (NUM_SEGMENTS)
  ) u_base_hi_ram (
    .clk_i   (clk_i),
    .we_i    (hi_we),
    .waddr_i (wr_idx),
    .wdata_i (wdata_i),
    .re_i    (is_xlate),
    .raddr_i (rd_idx),
    .rdata_o (hi_rdata)
  );

  smmu_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (NUM_SEGMENTS)
  ) u_base_lo_ram (
    .clk_i   (clk_i),
    .we_i    (lo_we),
    .waddr_i (wr_idx),
    .wdata_i (wdata_i),
    .re_i    (is_xlate),
    .raddr_i (rd_idx),
    .rdata_o (lo_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      cnt_q    <= '0;
      hi_vld_q <= '0;
      lo_vld_q <= '0;
    end else begin
      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
      if (hi_we) begin
        hi_vld_q[wr_idx] <= 1'b1;
      end
      if (lo_we) begin
        lo_vld_q[wr_idx] <= 1'b1;
      end
    end
  end

  // Stage 1 waits on the RAM read; the valid bits are sampled with it.
  assign s1_valid_d = is_xlate || (s1_valid_q && !s1_move);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_xlate) begin
      s1_offset_q <= offset_i;
      s1_hi_vld_q <= hi_vld_q[rd_idx];
      s1_lo_vld_q <= lo_vld_q[rd_idx];
    end
  end

  assign base = {s1_hi_vld_q ? hi_rdata : '0, s1_lo_vld_q ? lo_rdata : '0};
  assign sum  = {base, {BYTE_W{1'b0}}} + {{(ADDR_W-OFFSET_W){1'b0}}, s1_offset_q};

  assign out_valid_d = s1_move || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      phys_q <= sum;
    end
  end

  assign out_valid_o = out_valid_q;
  assign phys_addr_o = phys_q;

endmodule

`default_nettype wire

FILE: sv/smmu_chk.sv
// Port-level checker for the segment translation block, bound to the top level.
`default_nettype none
`include "segment_mmu_translate_macros.svh"

module smmu_chk (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          func_i,
  input wire logic [7:0]                    port_i,
  input wire logic [smmu_pkg::BYTE_W-1:0]   wdata_i,
  input wire logic [6:0]                    segment_i,
  input wire logic [smmu_pkg::OFFSET_W-1:0] offset_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [smmu_pkg::ADDR_W-1:0]   phys_addr_o
);

  import smmu_pkg::*;

  `SMMU_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `SMMU_ASSERT(a_out_stable, out_valid_o && out_stall_i |=> $stable(phys_addr_o), "stalled result changed")
  `SMMU_ASSERT(a_in_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled without output backpressure")
  `SMMU_ASSERT(a_result_source, $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && func_i == FUNC_XLATE, 2), "result without a translate transaction")

endmodule

bind segment_mmu_translate smmu_chk u_smmu_chk (.*);

`default_nettype wire
